// ----- hw/rtl/tcs_pkg.sv -----
// Package for the tick-credit task scheduler: sizes, codes and the structs
// that pass between the sequencer, the task table and the shared compare unit.
// No dependencies.
package tcs_pkg;

  // Number of task slots and the width of a slot index.
  localparam int NUM_TASKS = 16;
  localparam int IDX_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  // Credit and priority given to slot 0 and the reset value of the default.
  localparam logic [7:0] INITIAL_CREDIT = 8'd10;

  typedef logic [IDX_W-1:0] idx_t;

  // Input word modes.
  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_CREATE  = 2'd1,
    MODE_SET_RUN = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_CREDIT,
    ST_SCAN_PRIO,
    ST_DEC,
    ST_CREATE
  } state_t;

  // Task table write operations.
  typedef enum logic [2:0] {
    TBL_NOP,
    TBL_SET_RUN,
    TBL_LOAD_CREDIT,
    TBL_SET_CREDIT,
    TBL_CREATE
  } tbl_op_t;

  // One slot of the task table as seen on the read port.
  typedef struct packed {
    logic       valid;
    logic       runnable;
    logic [7:0] credit;
    logic [7:0] prio;
  } entry_t;

  // Write command into the task table.
  typedef struct packed {
    tbl_op_t    op;
    idx_t       idx;
    logic [7:0] value;
    logic       run;
  } tbl_wr_t;

  // Shared compare unit operands and results.
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
  } alu_in_t;

  typedef struct packed {
    logic       gt;
    logic [7:0] dec;
  } alu_out_t;

endpackage

// ----- hw/rtl/tcs_alu.sv -----
// Shared compare unit of the scheduler: an 8-bit greater-than compare and a
// saturating decrement. Depends on tcs_pkg.
module tcs_alu
  import tcs_pkg::*;
(
  input  alu_in_t  alu_in,
  output alu_out_t alu_out
);

  // Compare the scanned value against the best so far.
  assign alu_out.gt = (alu_in.a > alu_in.b);

  // Saturating decrement of the first operand.
  assign alu_out.dec = (alu_in.a == 8'd0) ? 8'd0 : (alu_in.a - 8'd1);

endmodule

// ----- hw/rtl/tcs_table.sv -----
// Task table: per-slot valid, runnable, credit and priority, with one read
// port at the scan index and one write port. Depends on tcs_pkg.
module tcs_table
  import tcs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  idx_t    rd_idx,
  output entry_t  rd_entry,
  input  tbl_wr_t wr
);

  logic [NUM_TASKS-1:0] valid_r;
  logic [NUM_TASKS-1:0] runnable_r;
  logic [7:0]           credit_r [NUM_TASKS];
  logic [7:0]           prio_r   [NUM_TASKS];

  // Single read port at the sequencer's scan index.
  assign rd_entry.valid    = valid_r[rd_idx];
  assign rd_entry.runnable = runnable_r[rd_idx];
  assign rd_entry.credit   = credit_r[rd_idx];
  assign rd_entry.prio     = prio_r[rd_idx];

  // Table update; after reset only slot 0 is a live task.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= NUM_TASKS'(1);
      runnable_r <= NUM_TASKS'(1);
      for (int i = 0; i < NUM_TASKS; i++) begin
        credit_r[i] <= (i == 0) ? INITIAL_CREDIT : 8'd0;
        prio_r[i]   <= (i == 0) ? INITIAL_CREDIT : 8'd0;
      end
    end else begin
      unique case (wr.op)
        TBL_NOP: begin
        end
        TBL_SET_RUN: begin
          runnable_r[wr.idx] <= wr.run;
        end
        TBL_LOAD_CREDIT: begin
          credit_r[wr.idx] <= prio_r[wr.idx];
        end
        TBL_SET_CREDIT: begin
          credit_r[wr.idx] <= wr.value;
        end
        TBL_CREATE: begin
          valid_r[wr.idx]    <= 1'b1;
          runnable_r[wr.idx] <= 1'b1;
          credit_r[wr.idx]   <= wr.value;
          prio_r[wr.idx]     <= wr.value;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/tick_credit_task_scheduler.sv -----
// Tick-credit task scheduler: sequencer, configuration register and result
// registers; uses tcs_table and tcs_alu, types from tcs_pkg.
// A tick scans all NUM_TASKS slots in one or two passes, then a decrement state;
// a create walks the slots up to the first free one; other words finish in the
// accept cycle. The result strobe is registered, so it rises in the cycle after
// the word's last state. The receiver cannot stall; one slot compare per cycle
// sets the time.
// Synchronous active-low reset: idle, slot 0 current, default priority 10.
module tick_credit_task_scheduler
  import tcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // Input words.
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_mode,
  input  logic [1:0] in_cpl,
  input  logic [3:0] in_slot,
  input  logic       in_runnable,
  // Result words.
  output logic       out_valid,
  output logic [3:0] out_current_slot,
  output logic       out_switched,
  output logic       out_same_task_error,
  output logic [3:0] out_created_slot,
  output logic       out_table_full,
  // Configuration.
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  localparam idx_t LAST_IDX = IDX_W'(NUM_TASKS - 1);

  state_t     state_r, state_nxt;
  idx_t       idx_r, idx_nxt;
  idx_t       pick_r, pick_nxt;
  idx_t       cur_r, cur_nxt;
  logic [7:0] best_r, best_nxt;
  logic [7:0] default_prio_r;

  logic       out_valid_r, out_valid_nxt;
  logic [3:0] out_current_r, out_current_nxt;
  logic       out_switched_r, out_switched_nxt;
  logic       out_err_r, out_err_nxt;
  logic [3:0] out_created_r, out_created_nxt;
  logic       out_full_r, out_full_nxt;

  entry_t   rd_entry;
  tbl_wr_t  wr;
  alu_in_t  alu_in;
  alu_out_t alu_out;
  logic     not_cur;
  logic     take;

  tcs_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (idx_r),
    .rd_entry (rd_entry),
    .wr       (wr)
  );

  tcs_alu u_alu (
    .alu_in  (alu_in),
    .alu_out (alu_out)
  );

  // The second scan compares priorities; everything else works on credit.
  assign alu_in.a = (state_r == ST_SCAN_PRIO) ? rd_entry.prio : rd_entry.credit;
  assign alu_in.b = best_r;

  // A scanned slot is a candidate when it is a live, runnable, other task.
  assign not_cur = (idx_r != cur_r);
  assign take    = rd_entry.valid && rd_entry.runnable && not_cur && alu_out.gt;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_prio_r <= INITIAL_CREDIT;
    end else if (cfg_wr_en) begin
      default_prio_r <= cfg_wr_data;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Scan registers and result word.
  always_ff @(posedge clk) begin
    idx_r          <= idx_nxt;
    pick_r         <= pick_nxt;
    best_r         <= best_nxt;
    out_current_r  <= out_current_nxt;
    out_switched_r <= out_switched_nxt;
    out_err_r      <= out_err_nxt;
    out_created_r  <= out_created_nxt;
    out_full_r     <= out_full_nxt;
  end

  // Sequencer.
  always_comb begin
    state_nxt        = state_r;
    idx_nxt          = idx_r;
    pick_nxt         = pick_r;
    best_nxt         = best_r;
    cur_nxt          = cur_r;
    wr.op            = TBL_NOP;
    wr.idx           = idx_r;
    wr.value         = 8'd0;
    wr.run           = 1'b0;
    out_valid_nxt    = 1'b0;
    out_current_nxt  = out_current_r;
    out_switched_nxt = out_switched_r;
    out_err_nxt      = out_err_r;
    out_created_nxt  = out_created_r;
    out_full_nxt     = out_full_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          // Default result for a word that finishes right away.
          out_current_nxt  = 4'(cur_r);
          out_switched_nxt = 1'b0;
          out_err_nxt      = 1'b0;
          out_created_nxt  = 4'd0;
          out_full_nxt     = 1'b0;
          unique case (mode_t'(in_mode))
            MODE_TICK: begin
              if (in_cpl == 2'd0 && cur_r == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = ST_SCAN_CREDIT;
                idx_nxt   = '0;
                pick_nxt  = '0;
                best_nxt  = 8'd0;
              end
            end
            MODE_CREATE: begin
              state_nxt = ST_CREATE;
              idx_nxt   = '0;
            end
            MODE_SET_RUN: begin
              if (32'(in_slot) < 32'(NUM_TASKS)) begin
                wr.op  = TBL_SET_RUN;
                wr.idx = IDX_W'(in_slot);
                wr.run = in_runnable;
              end
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      // First pass: most credit among candidates, lowest slot on ties.
      ST_SCAN_CREDIT: begin
        if (take) begin
          best_nxt = rd_entry.credit;
          pick_nxt = idx_r;
        end
        if (idx_r == LAST_IDX) begin
          if (best_nxt == 8'd0) begin
            state_nxt = ST_SCAN_PRIO;
            idx_nxt   = '0;
          end else begin
            state_nxt = ST_DEC;
            idx_nxt   = pick_nxt;
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      // Second pass: reload credit from priority and pick by priority.
      ST_SCAN_PRIO: begin
        if (rd_entry.valid && not_cur) begin
          wr.op = TBL_LOAD_CREDIT;
        end
        if (take) begin
          best_nxt = rd_entry.prio;
          pick_nxt = idx_r;
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_DEC;
          idx_nxt   = pick_nxt;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      // Charge one tick to the chosen slot and make it current.
      ST_DEC: begin
        wr.op            = TBL_SET_CREDIT;
        wr.value         = alu_out.dec;
        cur_nxt          = idx_r;
        out_current_nxt  = 4'(idx_r);
        out_switched_nxt = 1'b1;
        out_err_nxt      = (idx_r == cur_r);
        out_valid_nxt    = 1'b1;
        state_nxt        = ST_IDLE;
      end

      // Walk the table for the lowest free slot.
      ST_CREATE: begin
        if (!rd_entry.valid) begin
          wr.op           = TBL_CREATE;
          wr.value        = default_prio_r;
          out_created_nxt = 4'(idx_r);
          out_valid_nxt   = 1'b1;
          state_nxt       = ST_IDLE;
        end else if (idx_r == LAST_IDX) begin
          out_full_nxt  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy                = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_current_slot    = out_current_r;
  assign out_switched        = out_switched_r;
  assign out_same_task_error = out_err_r;
  assign out_created_slot    = out_created_r;
  assign out_table_full      = out_full_r;

  // A result is only presented once the sequencer is back to idle.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while the sequencer is busy");

  // A tick that is not a kernel tick while the idle task runs must start a scan.
  a_tick_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == MODE_TICK && !(in_cpl == 2'd0 && cur_r == '0))
    |=> busy)
    else $error("scheduling tick did not start a scan");

  // Only a scheduling decision can choose the current task.
  a_err_needs_switch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_same_task_error) |-> out_switched)
    else $error("same-task error without a scheduling decision");

  // A full table never reports a created slot.
  a_full_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |-> (out_created_slot == 4'd0))
    else $error("table full reported together with a created slot");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the tick-credit task scheduler: directed and random
// words against a behavioral scheduler model; depends on tcs_pkg and the RTL top.
`timescale 1ns / 1ps

module tb_top;
  import tcs_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 40;

  // One expected result word.
  typedef struct {
    logic [3:0] current_slot;
    logic       switched;
    logic       same_task_error;
    logic [3:0] created_slot;
    logic       table_full;
  } sched_result_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] in_mode;
  logic [1:0] in_cpl;
  logic [3:0] in_slot;
  logic       in_runnable;
  logic       out_valid;
  logic [3:0] out_current_slot;
  logic       out_switched;
  logic       out_same_task_error;
  logic [3:0] out_created_slot;
  logic       out_table_full;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  // Shadow copy of the task table and the scheduler registers.
  logic       slot_live [NUM_TASKS];
  logic       slot_ready [NUM_TASKS];
  logic [7:0] credit_left [NUM_TASKS];
  logic [7:0] slot_prio [NUM_TASKS];
  idx_t       cur_slot;
  logic [7:0] dflt_prio;

  sched_result_t results_due[$];
  int unsigned   mismatches;
  int unsigned   cycle_count;
  bit            gaps_on;

  tick_credit_task_scheduler dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_mode             (in_mode),
    .in_cpl              (in_cpl),
    .in_slot             (in_slot),
    .in_runnable         (in_runnable),
    .out_valid           (out_valid),
    .out_current_slot    (out_current_slot),
    .out_switched        (out_switched),
    .out_same_task_error (out_same_task_error),
    .out_created_slot    (out_created_slot),
    .out_table_full      (out_table_full),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  // Clock.
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Run guard: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[tick_credit_task_scheduler] ERROR");
      $finish;
    end
  end

  // Scheduler state right after reset.
  task automatic clear_schedule_state();
    for (int i = 0; i < NUM_TASKS; i++) begin
      slot_live[i] = 1'b0;
      slot_ready[i] = 1'b0;
      credit_left[i] = 8'd0;
      slot_prio[i] = 8'd0;
    end
    slot_live[0] = 1'b1;
    slot_ready[0] = 1'b1;
    credit_left[0] = INITIAL_CREDIT;
    slot_prio[0] = INITIAL_CREDIT;
    cur_slot = '0;
    dflt_prio = INITIAL_CREDIT;
  endtask

  // Apply one accepted word to the shadow state and return the result it causes.
  task automatic schedule_word(input mode_t m, input logic [1:0] cpl, input logic [3:0] slot,
                               input logic run, output sched_result_t r);
    int unsigned best;
    int          pick;
    bit          found;
    r = '{default: '0};
    best = 0;
    pick = 0;
    found = 1'b0;
    case (m)
      MODE_TICK: begin
        // A kernel tick while the idle task runs leaves everything alone.
        if (!(cpl == 2'd0 && cur_slot == '0)) begin
          for (int i = 0; i < NUM_TASKS; i++) begin
            if (slot_live[i] && i != int'(cur_slot) && slot_ready[i] &&
                credit_left[i] > best) begin
              best = credit_left[i];
              pick = i;
            end
          end
          // Nobody has credit left: refill from priorities and pick by priority.
          if (best == 0) begin
            for (int i = 0; i < NUM_TASKS; i++) begin
              if (slot_live[i] && i != int'(cur_slot)) begin
                credit_left[i] = slot_prio[i];
                if (slot_ready[i] && slot_prio[i] > best) begin
                  best = slot_prio[i];
                  pick = i;
                end
              end
            end
          end
          if (credit_left[pick] != 8'd0) credit_left[pick] = credit_left[pick] - 8'd1;
          r.switched = 1'b1;
          r.same_task_error = (pick == int'(cur_slot));
          cur_slot = idx_t'(pick);
        end
      end
      MODE_CREATE: begin
        for (int i = 0; i < NUM_TASKS; i++) begin
          if (!found && !slot_live[i]) begin
            found = 1'b1;
            slot_live[i] = 1'b1;
            slot_ready[i] = 1'b1;
            credit_left[i] = dflt_prio;
            slot_prio[i] = dflt_prio;
            r.created_slot = 4'(i);
          end
        end
        r.table_full = !found;
      end
      MODE_SET_RUN: begin
        if (int'(slot) < NUM_TASKS) slot_ready[slot] = run;
      end
      default: begin
      end
    endcase
    r.current_slot = 4'(cur_slot);
  endtask

  // Send one word; returns at the falling edge after it was accepted, start still high.
  task automatic send_word(input mode_t m, input logic [1:0] cpl, input logic [3:0] slot,
                           input logic run);
    sched_result_t r;
    // Each idle cycle is drawn on its own: another one follows with a chance of 31 in 100.
    if (gaps_on) begin
      while ($urandom_range(99) < 31) begin
        start <= 1'b0;
        @(negedge clk);
      end
    end
    start <= 1'b1;
    in_mode <= m;
    in_cpl <= cpl;
    in_slot <= slot;
    in_runnable <= run;
    do @(posedge clk); while (busy);
    schedule_word(m, cpl, slot, run, r);
    results_due.push_back(r);
    @(negedge clk);
  endtask

  // Random word: mostly ticks and runnable updates, with a few creations and unused words.
  task automatic send_random_word();
    int unsigned pick;
    mode_t m;
    pick = $urandom_range(99);
    if (pick < 50) m = MODE_TICK;
    else if (pick < 56) m = MODE_CREATE;
    else if (pick < 94) m = MODE_SET_RUN;
    else m = MODE_UNUSED;
    send_word(m, 2'($urandom_range(3)), 4'($urandom_range(15)), $urandom_range(99) < 70);
  endtask

  // Stop sending and wait until the block has answered every word.
  task automatic wait_until_settled();
    start <= 1'b0;
    while (results_due.size() != 0 || busy) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Write the default priority; only called while the block is idle.
  task automatic set_default_priority(input logic [7:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    dflt_prio = value;
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare every result word with the oldest outstanding expectation.
  always @(posedge clk) begin : check_words
    sched_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (results_due.size() == 0) begin
        $error("result word with nothing outstanding: current_slot %0d", out_current_slot);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        check_field("current_slot", 8'(want.current_slot), 8'(out_current_slot));
        check_field("switched", 8'(want.switched), 8'(out_switched));
        check_field("same_task_error", 8'(want.same_task_error), 8'(out_same_task_error));
        check_field("created_slot", 8'(want.created_slot), 8'(out_created_slot));
        check_field("table_full", 8'(want.table_full), 8'(out_table_full));
      end
    end
  end

  // Ticks with only the idle task present, plus the words that change nothing.
  task automatic test_idle_task_ticks();
    send_word(MODE_TICK, 2'd0, 4'd0, 1'b0);
    send_word(MODE_TICK, 2'd3, 4'd15, 1'b1);
    send_word(MODE_UNUSED, 2'd2, 4'd9, 1'b1);
    send_word(MODE_SET_RUN, 2'd1, 4'd5, 1'b0);
    send_word(MODE_SET_RUN, 2'd0, 4'd15, 1'b1);
  endtask

  // Ties, credit refill and fallback to the idle task with the lowest default.
  task automatic test_credit_and_refill();
    wait_until_settled();
    set_default_priority(8'd1);
    send_word(MODE_CREATE, 2'd0, 4'd0, 1'b0);
    send_word(MODE_CREATE, 2'd3, 4'd0, 1'b0);
    send_word(MODE_TICK, 2'd0, 4'd0, 1'b0);
    send_word(MODE_TICK, 2'd3, 4'd0, 1'b0);
    send_word(MODE_TICK, 2'd0, 4'd0, 1'b0);
    send_word(MODE_TICK, 2'd2, 4'd0, 1'b0);
    send_word(MODE_SET_RUN, 2'd0, 4'd0, 1'b0);
    send_word(MODE_TICK, 2'd1, 4'd0, 1'b0);
    send_word(MODE_SET_RUN, 2'd0, 4'd1, 1'b0);
    send_word(MODE_SET_RUN, 2'd0, 4'd2, 1'b0);
    send_word(MODE_TICK, 2'd1, 4'd0, 1'b0);
    send_word(MODE_TICK, 2'd3, 4'd0, 1'b0);
    send_word(MODE_SET_RUN, 2'd0, 4'd0, 1'b1);
    send_word(MODE_SET_RUN, 2'd0, 4'd2, 1'b1);
    send_word(MODE_TICK, 2'd1, 4'd0, 1'b0);
  endtask

  // One random phase under a given default priority.
  task automatic test_random_traffic(input logic [7:0] prio, input int count, input bit gaps);
    wait_until_settled();
    set_default_priority(prio);
    gaps_on = gaps;
    repeat (count) send_random_word();
  endtask

  // Fill every free slot and ask again to see the full flag, then send random words.
  task automatic test_full_table();
    wait_until_settled();
    set_default_priority(8'd10);
    repeat (NUM_TASKS) send_word(MODE_CREATE, 2'($urandom_range(3)), 4'd0, 1'b0);
    repeat (20) send_random_word();
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = MODE_TICK;
    in_cpl = 2'd0;
    in_slot = 4'd0;
    in_runnable = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 8'd0;
    mismatches = 0;
    cycle_count = 0;
    gaps_on = 1'b1;
    clear_schedule_state();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_idle_task_ticks();
    test_credit_and_refill();
    test_random_traffic(8'd255, 150, 1'b1);
    test_random_traffic(8'd128, 150, 1'b0);
    test_random_traffic(8'd1, 150, 1'b1);
    test_random_traffic(8'($urandom_range(1, 255)), 150, 1'b1);
    test_random_traffic(8'd10, 130, 1'b1);
    test_full_table();

    wait_until_settled();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("[tick_credit_task_scheduler] OK");
    end else begin
      $display("[tick_credit_task_scheduler] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/tcs_pkg.sv
hw/rtl/tcs_alu.sv
hw/rtl/tcs_table.sv
hw/rtl/tick_credit_task_scheduler.sv
bench/tb_top.sv
